/* sv/ppm_pkg.sv */
// shared constants and types for the ppm peak merger
`timescale 1ns / 1ps
`default_nettype none

package ppm_pkg;

    localparam int MZ_W      = 32;               // m/z word, 16 fraction bits
    localparam int IN_INT_W  = 32;               // input intensity
    localparam int INT_W     = 40;               // accumulated intensity
    localparam int SUM_W     = INT_W + 1;        // exact intensity sum
    localparam int TOL_W     = 10;
    localparam int PPM_W     = 20;               // width of the ppm scale constant
    localparam int PROD_W    = MZ_W + PPM_W;     // window products
    localparam int NUM_W     = MZ_W + INT_W + 1; // weighted sum numerator
    localparam int CNT_W     = 6;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(20);
    localparam logic [PPM_W-1:0] PPM_SCALE = PPM_W'(1000000);

    localparam logic [CNT_W-1:0] WIN_STEPS = CNT_W'(PPM_W);
    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(INT_W);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(MZ_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN,
        ST_CMP,
        ST_MUL,
        ST_DIV,
        ST_UPD,
        ST_SEP,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic s_ready;
        logic push;
        logic push_last;
    } t_ctl;

endpackage

`default_nettype wire

/* sv/ppm_peak_merger_top.sv */
// Peak merger: folds m/z-sorted peaks into intensity-weighted centroids within a ppm window.
// One peak is worked on at a time and s_tready stays low until it is done. A peak that finds
// no open peak just opens it. A peak outside the window, or one that merges with a zero
// intensity sum, needs only the window test: a bit-serial multiply forms both sides of the
// window test. A peak that merges takes the window test, then a bit-serial
// multiply-accumulate for the weighted m/z sum, then a radix-2 restoring
// divide by the intensity sum. Emitting a result, for a split or for the flush of the last
// peak, stalls only while the output register still holds an unaccepted word. The output
// register lets the next peak be taken while a result waits. The tolerance register may be
// written only when idle.
`timescale 1ns / 1ps
`default_nettype none

module ppm_peak_merger_top
    import ppm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // peak input
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [63:0]            s_tdata,   // peak_mz[31:0], peak_intensity[63:32]
    input  wire logic                   s_tlast,   // last_peak
    // tolerance write
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [TOL_W-1:0]       i_cfg_data,
    // merged peak output
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [71:0]                 m_tdata,   // merged_mz[31:0], merged_intensity[71:32]
    output logic                        m_tlast    // last_merged
);

    t_state               r_state, n_state;
    t_ctl                 ctl;

    logic [TOL_W-1:0]     r_tol;
    logic [MZ_W-1:0]      r_open_mz;
    logic [INT_W-1:0]     r_open_int;
    logic                 r_open_valid;

    logic [MZ_W-1:0]      r_in_mz;
    logic [IN_INT_W-1:0]  r_in_int;
    logic                 r_in_last;
    logic [MZ_W-1:0]      r_diff;
    logic [INT_W-1:0]     r_bits_a, r_bits_b;
    logic [PROD_W-1:0]    r_lhs, r_rhs;
    logic [NUM_W-1:0]     r_num;
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_cnt;

    logic                 r_m_tvalid;
    logic [71:0]          r_m_tdata;
    logic                 r_m_tlast;

    logic [MZ_W-1:0]      w_s_mz;
    logic [IN_INT_W-1:0]  w_s_int;
    logic [MZ_W-1:0]      w_diff;
    logic                 w_accept;
    logic                 w_slot;
    logic                 w_cnt_done;
    logic                 w_in_win;
    logic [SUM_W-1:0]     w_sum;
    logic                 w_sum_nz;
    logic [MZ_W:0]        w_lhs_t, w_rhs_t;
    logic [MZ_W+1:0]      w_mul_t;
    logic [SUM_W:0]       w_div_t, w_div_r;
    logic                 w_div_ge;
    logic [INT_W-1:0]     w_sat;

    assign w_s_mz     = s_tdata[MZ_W-1:0];
    assign w_s_int    = s_tdata[MZ_W+IN_INT_W-1:MZ_W];
    assign w_diff     = (w_s_mz >= r_open_mz) ? (w_s_mz - r_open_mz) : (r_open_mz - w_s_mz);
    assign w_accept   = s_tvalid && ctl.s_ready;
    assign w_slot     = !r_m_tvalid || m_tready;
    assign w_cnt_done = (r_cnt == '0);
    assign w_in_win   = (r_lhs <= r_rhs);
    assign w_sum      = {1'b0, r_open_int} + {{(SUM_W-IN_INT_W){1'b0}}, r_in_int};
    assign w_sum_nz   = (r_open_int != '0) || (r_in_int != '0);

    // shift-right multiply steps, one multiplier bit per cycle
    assign w_lhs_t = {1'b0, r_lhs[PROD_W-1:PPM_W]} + (r_bits_a[0] ? {1'b0, r_diff} : '0);
    assign w_rhs_t = {1'b0, r_rhs[PROD_W-1:PPM_W]} + (r_bits_b[0] ? {1'b0, r_open_mz} : '0);
    assign w_mul_t = {1'b0, r_num[NUM_W-1:INT_W]}
                   + (r_bits_a[0] ? {2'b0, r_open_mz} : '0)
                   + (r_bits_b[0] ? {2'b0, r_in_mz} : '0);

    // restoring divide in place: remainder above, numerator bits shift out as quotient bits shift in
    assign w_div_t  = {r_num[NUM_W-1:MZ_W], r_num[MZ_W-1]};
    assign w_div_ge = (w_div_t >= {1'b0, r_sum});
    assign w_div_r  = w_div_t - {1'b0, r_sum};

    assign w_sat = r_sum[SUM_W-1] ? {INT_W{1'b1}} : r_sum[INT_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = r_open_valid ? ST_WIN : ST_FLUSH;
                end
            end
            ST_WIN: begin
                if (w_cnt_done) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (!w_in_win) begin
                    n_state = ST_SEP;
                end else if (w_sum_nz) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_UPD;
                end
            end
            ST_MUL: begin
                if (w_cnt_done) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_cnt_done) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                n_state = ST_FLUSH;
            end
            ST_SEP: begin
                if (w_slot) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_in_last || w_slot) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        ctl = '0;
        case (r_state)
            ST_IDLE: begin
                ctl.s_ready = 1'b1;
            end
            ST_SEP: begin
                ctl.push = w_slot;
            end
            ST_FLUSH: begin
                ctl.push      = r_in_last && w_slot;
                ctl.push_last = 1'b1;
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

    // control and open peak state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tol        <= TOL_RESET;
            r_open_mz    <= '0;
            r_open_int   <= '0;
            r_open_valid <= 1'b0;
            r_m_tvalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_tol <= i_cfg_data;
            end
            if (ctl.push) begin
                r_m_tvalid <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept && !r_open_valid) begin
                        r_open_mz    <= w_s_mz;
                        r_open_int   <= {{(INT_W-IN_INT_W){1'b0}}, w_s_int};
                        r_open_valid <= 1'b1;
                    end
                end
                ST_UPD: begin
                    if (r_sum != '0) begin
                        r_open_mz <= r_num[MZ_W-1:0];
                    end
                    r_open_int <= w_sat;
                end
                ST_SEP: begin
                    if (w_slot) begin
                        r_open_mz  <= r_in_mz;
                        r_open_int <= {{(INT_W-IN_INT_W){1'b0}}, r_in_int};
                    end
                end
                ST_FLUSH: begin
                    if (ctl.push) begin
                        r_open_mz    <= '0;
                        r_open_int   <= '0;
                        r_open_valid <= 1'b0;
                    end
                end
                default: begin
                    r_open_valid <= r_open_valid;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (ctl.push) begin
            r_m_tdata <= {r_open_int, r_open_mz};
            r_m_tlast <= ctl.push_last;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_in_mz   <= w_s_mz;
                    r_in_int  <= w_s_int;
                    r_in_last <= s_tlast;
                    r_diff    <= w_diff;
                    r_bits_a  <= {{(INT_W-PPM_W){1'b0}}, PPM_SCALE};
                    r_bits_b  <= {{(INT_W-TOL_W){1'b0}}, r_tol};
                    r_lhs     <= '0;
                    r_rhs     <= '0;
                    r_cnt     <= WIN_STEPS - CNT_W'(1);
                end
            end
            ST_WIN: begin
                r_lhs    <= {w_lhs_t, r_lhs[PPM_W-1:1]};
                r_rhs    <= {w_rhs_t, r_rhs[PPM_W-1:1]};
                r_bits_a <= {1'b0, r_bits_a[INT_W-1:1]};
                r_bits_b <= {1'b0, r_bits_b[INT_W-1:1]};
                r_cnt    <= r_cnt - CNT_W'(1);
            end
            ST_CMP: begin
                r_sum    <= w_sum;
                r_bits_a <= r_open_int;
                r_bits_b <= {{(INT_W-IN_INT_W){1'b0}}, r_in_int};
                r_num    <= '0;
                r_cnt    <= MUL_STEPS - CNT_W'(1);
            end
            ST_MUL: begin
                r_num    <= {w_mul_t, r_num[INT_W-1:1]};
                r_bits_a <= {1'b0, r_bits_a[INT_W-1:1]};
                r_bits_b <= {1'b0, r_bits_b[INT_W-1:1]};
                r_cnt    <= w_cnt_done ? (DIV_STEPS - CNT_W'(1)) : (r_cnt - CNT_W'(1));
            end
            ST_DIV: begin
                r_num <= {(w_div_ge ? w_div_r[SUM_W-1:0] : w_div_t[SUM_W-1:0]),
                          r_num[MZ_W-2:0], w_div_ge};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign s_tready    = ctl.s_ready;
    assign o_cfg_ready = 1'b1;
    assign m_tvalid    = r_m_tvalid;
    assign m_tdata     = r_m_tdata;
    assign m_tlast     = r_m_tlast;

endmodule

`default_nettype wire

/* sv/ppm_checker.sv */
// port-level checks for the ppm peak merger, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ppm_checker
    import ppm_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_s_tvalid,
    input wire logic              i_s_tready,
    input wire logic              i_m_tvalid,
    input wire logic              i_m_tready,
    input wire logic [71:0]       i_m_tdata,
    input wire logic              i_m_tlast
);

    // output side comes up empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output word valid right after reset");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))
        else $error("stalled output word changed");

    // one peak at a time: no new word right after one is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input ready right after an accepted word");

    // results are only produced while a peak is being worked on
    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_m_tvalid) |-> $past(!i_s_tready))
        else $error("result appeared while input side idle");

endmodule

bind ppm_peak_merger_top ppm_checker u_ppm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_tvalid),
    .i_s_tready (s_tready),
    .i_m_tvalid (m_tvalid),
    .i_m_tready (m_tready),
    .i_m_tdata  (m_tdata),
    .i_m_tlast  (m_tlast)
);

`default_nettype wire
